// ----- rtl/ir90_pkg.sv -----
// ----------------------------------------------------------------------------
// ir90_pkg
// Shared types and constants of the 90 degree frame rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package ir90_pkg;

  // Width of one pixel on the stream ports.
  localparam int unsigned PIX_W = 8;

  // Width of a dimension register and of the register index.
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 8;

  // Reset value of both dimension registers.
  localparam logic [CFG_W-1:0] CFG_RESET_DIM = 7'd64;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_HEIGHT = 8'd0,
    CFG_FRAME_WIDTH  = 8'd1
  } cfg_reg_e;

  // Side flags that travel with each output pixel.
  typedef struct packed {
    logic frame_end;
    logic frame_valid;
  } ir90_flags_t;

endpackage

`default_nettype wire

// ----- rtl/image_rotate_90.sv -----
// ----------------------------------------------------------------------------
// image_rotate_90
// Streaming frame rotator, 90 degrees counterclockwise, double buffered.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels of a frame enter on the s_axis channel in row-major order. Source
//   pixel (row i, column j) is stored at row width-1-j, column i of the fill
//   bank, while the previous frame is read out of the other bank in raster
//   order on the m_axis channel: one output beat for every input beat. tlast
//   marks the last pixel of an output frame; tuser is low while the first
//   frame is still loading, when the pixels read out are zeros.
//   The cfg channel writes frame height (index 0) and width (index 1); a
//   write restarts the frame position and holds s_axis_tready low one cycle.
//   Throughput is one pixel per cycle while s_axis_tready is high, set by
//   the single write and single read port of each bank; the receiver, the
//   clearing pass and a dimension write can hold it low. An input beat
//   reaches m_axis through the bank read register, then the output buffer.
// Reset and stalls:
//   After reset a clearing pass zeros both banks, with s_axis_tready low.
//   When the receiver stalls, up to three results are held (read register
//   plus a two-entry buffer) before s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module image_rotate_90 #(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input pixel stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [ir90_pkg::PIX_W-1:0]     s_axis_tdata,  // [7:0] pixel_in
  // Output pixel stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [ir90_pkg::PIX_W-1:0]     m_axis_tdata,  // [7:0] pixel_out
  output logic                                m_axis_tlast,  // frame_end
  output logic                                m_axis_tuser,  // [0] frame_valid
  // Configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ir90_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ir90_pkg::CFG_W-1:0]     cfg_data_i
);

  import ir90_pkg::*;

  localparam int unsigned Depth  = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned StoreW = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int unsigned BufW   = PIX_W + $bits(ir90_flags_t);

  logic              acc;
  logic              cfg_we;
  logic [AddrW-1:0]  waddr, raddr;
  logic              fill_bank;
  ir90_flags_t       flags;
  logic              settle;
  logic [StoreW-1:0] rdata;
  logic              clear_busy;

  logic              a_valid_q;
  ir90_flags_t       a_flags_q;
  logic              a_push;
  logic              buf_ready;
  logic [BufW-1:0]   buf_in, buf_out;
  ir90_flags_t       out_flags;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Accept when the read stage is free or moves on into the buffer.
  assign s_axis_tready = !clear_busy && !settle && (!a_valid_q || buf_ready);
  assign acc           = s_axis_tvalid && s_axis_tready;

  ir90_addr_gen #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (AddrW)
  ) u_addr_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (acc),
    .waddr_o     (waddr),
    .raddr_o     (raddr),
    .fill_bank_o (fill_bank),
    .flags_o     (flags),
    .settle_o    (settle)
  );

  ir90_frame_mem #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW),
    .DATA_W (StoreW)
  ) u_frame_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (acc),
    .fill_bank_i  (fill_bank),
    .waddr_i      (waddr),
    .wdata_i      (s_axis_tdata[StoreW-1:0]),
    .raddr_i      (raddr),
    .rdata_o      (rdata),
    .clear_busy_o (clear_busy)
  );

  // Read stage: flags follow the registered bank read data.
  assign a_push = a_valid_q && buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (acc) begin
      a_valid_q <= 1'b1;
    end else if (a_push) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_flags_q <= flags;
    end
  end

  assign buf_in = {a_flags_q, PIX_W'(rdata)};

  ir90_out_buf #(
    .W (BufW)
  ) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (a_push),
    .data_i  (buf_in),
    .ready_o (buf_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .data_o  (buf_out)
  );

  assign out_flags    = buf_out[BufW-1:PIX_W];
  assign m_axis_tdata = buf_out[PIX_W-1:0];
  assign m_axis_tlast = out_flags.frame_end;
  assign m_axis_tuser = out_flags.frame_valid;

endmodule

`default_nettype wire

// ----- rtl/ir90_addr_gen.sv -----
// ----------------------------------------------------------------------------
// ir90_addr_gen
// Frame position counters, bank control and the rotated write address.
// ----------------------------------------------------------------------------
`default_nettype none

module ir90_addr_gen #(
  parameter int unsigned MAX_DIM = 64,
  parameter int unsigned ADDR_W  = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration writes
  input  wire logic                         cfg_we_i,
  input  wire logic [ir90_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ir90_pkg::CFG_W-1:0]     cfg_data_i,
  // One pixel beat accepted this cycle
  input  wire logic                         step_i,
  // Addresses and bank for the current beat
  output logic [ADDR_W-1:0]                 waddr_o,
  output logic [ADDR_W-1:0]                 raddr_o,
  output logic                              fill_bank_o,
  output ir90_pkg::ir90_flags_t             flags_o,
  // High for one cycle after a dimension register write
  output logic                              settle_o
);

  import ir90_pkg::*;

  localparam int unsigned DimW  = $clog2(MAX_DIM);
  localparam int unsigned SizeW = DimW + 1;
  localparam int unsigned ProdW = 2 * SizeW;
  localparam int unsigned ResetDimInt =
    (int'(CFG_RESET_DIM) > MAX_DIM) ? MAX_DIM : int'(CFG_RESET_DIM);
  localparam logic [SizeW-1:0]  DimReset    = SizeW'(ResetDimInt);
  localparam logic [ADDR_W-1:0] TotalM1Reset = ADDR_W'(ResetDimInt * ResetDimInt - 1);

  // Out-of-range dimensions: zero acts as one, above the maximum saturates.
  function automatic logic [SizeW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = SizeW'(MAX_DIM);
    end else begin
      r = SizeW'(v);
    end
    return r;
  endfunction

  logic [SizeW-1:0]  h_q, h_d, w_q, w_d;
  logic [ADDR_W-1:0] total_m1_q, total_m1_d;
  logic [DimW-1:0]   in_row_q, in_row_d, in_col_q, in_col_d;
  logic [ADDR_W-1:0] out_idx_q, out_idx_d;
  logic              bank_q, bank_d;
  logic              full_q, full_d;
  logic              settle_q, settle_d;

  logic              cfg_hit;
  logic              last;
  logic              col_wrap;
  logic [SizeW-1:0]  col_rev;
  logic [ProdW-1:0]  col_base;
  logic [ProdW-1:0]  waddr_wide;
  logic [ProdW-1:0]  area;

  // Frame size, kept registered so the end-of-frame compare is short.
  assign area       = ProdW'(h_q) * ProdW'(w_q);
  assign total_m1_d = ADDR_W'(area - ProdW'(1));

  // Rotated address: (width - 1 - col) * height + row.
  assign col_rev    = w_q - SizeW'(1) - SizeW'(in_col_q);
  assign col_base   = ProdW'(col_rev) * ProdW'(h_q);
  assign waddr_wide = col_base + ProdW'(in_row_q);

  assign last     = (out_idx_q == total_m1_q);
  assign col_wrap = (SizeW'(in_col_q) == (w_q - SizeW'(1)));
  assign cfg_hit  = cfg_we_i &&
                    ((cfg_index_i == CFG_FRAME_HEIGHT) || (cfg_index_i == CFG_FRAME_WIDTH));

  // Next state: a dimension write restarts the frame position, a beat
  // advances it and swaps banks at the end of a frame.
  always_comb begin
    h_d       = h_q;
    w_d       = w_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_idx_d = out_idx_q;
    bank_d    = bank_q;
    full_d    = full_q;
    settle_d  = 1'b0;
    if (cfg_hit) begin
      if (cfg_index_i == CFG_FRAME_HEIGHT) begin
        h_d = clamp_dim(cfg_data_i);
      end else begin
        w_d = clamp_dim(cfg_data_i);
      end
      in_row_d  = '0;
      in_col_d  = '0;
      out_idx_d = '0;
      settle_d  = 1'b1;
    end else if (step_i) begin
      if (last) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_idx_d = '0;
        bank_d    = ~bank_q;
        full_d    = 1'b1;
      end else begin
        out_idx_d = out_idx_q + ADDR_W'(1);
        if (col_wrap) begin
          in_col_d = '0;
          in_row_d = in_row_q + DimW'(1);
        end else begin
          in_col_d = in_col_q + DimW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q        <= DimReset;
      w_q        <= DimReset;
      total_m1_q <= TotalM1Reset;
      in_row_q   <= '0;
      in_col_q   <= '0;
      out_idx_q  <= '0;
      bank_q     <= 1'b0;
      full_q     <= 1'b0;
      settle_q   <= 1'b0;
    end else begin
      h_q        <= h_d;
      w_q        <= w_d;
      total_m1_q <= total_m1_d;
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      out_idx_q  <= out_idx_d;
      bank_q     <= bank_d;
      full_q     <= full_d;
      settle_q   <= settle_d;
    end
  end

  assign waddr_o           = ADDR_W'(waddr_wide);
  assign raddr_o           = out_idx_q;
  assign fill_bank_o       = bank_q;
  assign flags_o.frame_end   = last;
  assign flags_o.frame_valid = full_q;
  assign settle_o          = settle_q;

endmodule

`default_nettype wire

// ----- rtl/ir90_frame_mem.sv -----
// ----------------------------------------------------------------------------
// ir90_frame_mem
// Two frame banks with one write and one registered read per cycle, and a
// clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ir90_frame_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              fill_bank_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o,
  output logic                   clear_busy_o
);

  logic [DATA_W-1:0] bank0_q [DEPTH];
  logic [DATA_W-1:0] bank1_q [DEPTH];
  logic [DATA_W-1:0] rd0_q, rd1_q;
  logic              rsel_q;

  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              clr_busy_q, clr_busy_d;

  logic              we0, we1;
  logic [ADDR_W-1:0] wa;
  logic [DATA_W-1:0] wd;

  // Clearing sweep: one entry of each bank per cycle after reset.
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Write port: the sweep writes zeros to both banks, a beat writes the
  // fill bank only.
  assign we0 = clr_busy_q || (en_i && !fill_bank_i);
  assign we1 = clr_busy_q || (en_i &&  fill_bank_i);
  assign wa  = clr_busy_q ? clr_addr_q : waddr_i;
  assign wd  = clr_busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (we0) begin
      bank0_q[wa] <= wd;
    end
    if (en_i) begin
      rd0_q <= bank0_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      bank1_q[wa] <= wd;
    end
    if (en_i) begin
      rd1_q <= bank1_q[raddr_i];
    end
  end

  // The read bank is the one not being filled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsel_q <= ~fill_bank_i;
    end
  end

  assign rdata_o      = rsel_q ? rd1_q : rd0_q;
  assign clear_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// ----- rtl/ir90_out_buf.sv -----
// ----------------------------------------------------------------------------
// ir90_out_buf
// Two-entry output buffer that decouples the pipeline from the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module ir90_out_buf #(
  parameter int unsigned W = 10
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  wire logic         take_i,
  output logic      [W-1:0] data_o
);

  logic [W-1:0] ent_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q, count_d;
  logic         do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i && ready_o;
  assign do_pop  = take_i && valid_o;

  // Occupancy tracking.
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = ent_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- rtl/ir90_checker.sv -----
// ----------------------------------------------------------------------------
// ir90_checker
// Port-level checks of the frame rotator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ir90_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [ir90_pkg::PIX_W-1:0] m_axis_tdata,
  input wire logic                       m_axis_tlast,
  input wire logic                       m_axis_tuser
);

  import ir90_pkg::*;

  logic       in_beat, out_beat;
  logic [2:0] pend_q;
  logic       seen_valid_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Beats taken in but not yet delivered, and whether a full frame was seen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 3'd0;
      seen_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 3'(in_beat) - 3'(out_beat);
      if (out_beat && m_axis_tuser) begin
        seen_valid_q <= 1'b1;
      end
    end
  end

  // A stalled output beat keeps its content.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("output beat changed while stalled");

  // Every output beat answers an earlier input beat.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (pend_q != 3'd0))
    else $error("output beat without a pending input beat");

  // No more than three results are ever held inside.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 3'd3) |-> !s_axis_tready)
    else $error("input accepted with the pipeline full");

  // Once a frame_valid pixel has come out, every later pixel is flagged too.
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && seen_valid_q) |-> m_axis_tuser)
    else $error("frame_valid dropped after a full frame");

endmodule

bind image_rotate_90 ir90_checker u_ir90_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- sim/image_rotate_90_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_rotate_90_tb
// Self-checking testbench of the 90 degree counterclockwise frame rotator.
// ----------------------------------------------------------------------------
// A behavioral copy of the two frame banks predicts every output beat as each
// input beat is accepted; a monitor compares each output beat with the oldest
// prediction. Directed frames cover reset contents, degenerate dimensions and
// a small rotation; random frames then sweep dimensions, contents and cut-off
// frames under three idle patterns, plus one long receiver hold-off.
// ----------------------------------------------------------------------------

module image_rotate_90_tb;

  import ir90_pkg::*;

  localparam int unsigned MAX_DIM      = 64;
  localparam int unsigned BANK_WORDS   = MAX_DIM * MAX_DIM;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  // Any index above the two dimension registers is ignored by the block.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_IDX = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    ir90_flags_t      flags;
  } rot_pixel_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [PIX_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  image_rotate_90 #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (8)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Rotated pixels predicted but not yet seen on the output.
  rot_pixel_t rotated_pixels_q[$];

  // Behavioral copy of the rotator state.
  logic [PIX_W-1:0] bank_mem [0:2*BANK_WORDS-1];
  int unsigned      src_row;
  int unsigned      src_col;
  int unsigned      read_pos;
  logic             fill_bank;
  logic             frame_loaded;
  logic [CFG_W-1:0] height_reg;
  logic [CFG_W-1:0] width_reg;

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_request;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("image_rotate_90_tb: done, errors");
        $finish;
      end
    end
  end

  // A register value of zero acts as one, anything above the maximum as the maximum.
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  // Restore the predictor to its state after reset.
  task automatic reset_rotator_model();
    for (int i = 0; i < 2 * BANK_WORDS; i++) bank_mem[i] = '0;
    src_row      = 0;
    src_col      = 0;
    read_pos     = 0;
    fill_bank    = 1'b0;
    frame_loaded = 1'b0;
    height_reg   = CFG_RESET_DIM;
    width_reg    = CFG_RESET_DIM;
  endtask

  // One accepted pixel: read the previous frame in raster order and store the
  // new pixel at its rotated place in the fill bank.
  task automatic rotate_pixel(input logic [PIX_W-1:0] pix);
    int unsigned h, w, total, fill_base, read_base, waddr;
    rot_pixel_t  result;
    h     = eff_dim(height_reg);
    w     = eff_dim(width_reg);
    total = h * w;
    if (src_row >= h || src_col >= w || read_pos >= total) begin
      src_row  = 0;
      src_col  = 0;
      read_pos = 0;
    end
    fill_base = fill_bank ? BANK_WORDS : 0;
    read_base = fill_bank ? 0 : BANK_WORDS;

    result.pixel             = bank_mem[read_base + read_pos];
    result.flags.frame_end   = (read_pos == total - 1);
    result.flags.frame_valid = frame_loaded;
    rotated_pixels_q.push_back(result);

    waddr = (w - 1 - src_col) * h + src_row;
    bank_mem[fill_base + waddr] = pix;

    if (result.flags.frame_end) begin
      src_row      = 0;
      src_col      = 0;
      read_pos     = 0;
      fill_bank    = ~fill_bank;
      frame_loaded = 1'b1;
    end else begin
      read_pos++;
      src_col++;
      if (src_col >= w) begin
        src_col = 0;
        src_row++;
      end
    end
  endtask

  // Offer one pixel, possibly after a random gap, and wait for its beat.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    rotate_pixel(pix);
  endtask

  // Write one register once the block has delivered every pending pixel.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rotated_pixels_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // Only the two mapped registers restart the frame position.
    if (idx == CFG_FRAME_HEIGHT || idx == CFG_FRAME_WIDTH) begin
      if (idx == CFG_FRAME_HEIGHT) height_reg = val;
      else width_reg = val;
      src_row  = 0;
      src_col  = 0;
      read_pos = 0;
    end
    @(posedge clk_i);
  endtask

  // Mostly small dimensions, with zero, the maximum and out-of-range values mixed in.
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_W'($urandom_range(1, 8));
    if (r < 80) return CFG_W'($urandom_range(9, 64));
    if (r < 85) return '0;
    if (r < 90) return 7'd64;
    if (r < 95) return CFG_W'($urandom_range(65, 127));
    return 7'd127;
  endfunction

  // Output monitor: compare each output beat with the oldest prediction.
  always @(posedge clk_i) begin
    rot_pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rotated_pixels_q.size() == 0) begin
        $display("%0t: unexpected output beat: expected none, actual tdata=%h tlast=%b tuser=%b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        err_count++;
      end else begin
        want = rotated_pixels_q.pop_front();
        if (m_axis_tdata !== want.pixel) begin
          $display("%0t: pixel_out mismatch: expected %h actual %h",
                   $time, want.pixel, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tlast !== want.flags.frame_end) begin
          $display("%0t: frame_end mismatch: expected %b actual %b",
                   $time, want.flags.frame_end, m_axis_tlast);
          err_count++;
        end
        if (m_axis_tuser !== want.flags.frame_valid) begin
          $display("%0t: frame_valid mismatch: expected %b actual %b",
                   $time, want.flags.frame_valid, m_axis_tuser);
          err_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Part of a 64 by 64 frame right after reset: zeros, flagged not valid.
  task automatic test_first_frame();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    send_pixel(8'h01);
    send_pixel(8'h80);
    send_pixel(PIX_W'($urandom_range(0, 255)));
    send_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  // Ignored index, then zero dimensions that act as a one by one frame.
  task automatic test_degenerate_dims();
    write_reg(CFG_UNMAPPED_IDX, 7'h7F);
    write_reg(CFG_FRAME_HEIGHT, '0);
    write_reg(CFG_FRAME_WIDTH, '0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h7E);
    send_pixel(8'h81);
  endtask

  // Two 2 by 3 frames: the second reads out the first, rotated.
  task automatic test_small_rotation();
    write_reg(CFG_FRAME_HEIGHT, 7'd2);
    write_reg(CFG_FRAME_WIDTH, 7'd3);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    for (int i = 0; i < 10; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  // Tall and wide frames at the maximum, with an out-of-range register value.
  task automatic test_extreme_dims();
    write_reg(CFG_FRAME_HEIGHT, 7'd127);
    write_reg(CFG_FRAME_WIDTH, 7'd1);
    for (int i = 0; i < 2 * MAX_DIM; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
    write_reg(CFG_FRAME_HEIGHT, 7'd1);
    write_reg(CFG_FRAME_WIDTH, 7'd64);
    for (int i = 0; i < 2 * MAX_DIM; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  // Random dimensions and contents; some frames are cut off by the next write.
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned      done_items, h, w, n_frames, len;
    logic [CFG_W-1:0] raw_h, raw_w;
    done_items = 0;
    while (done_items < n_items) begin
      raw_h = pick_dim();
      raw_w = pick_dim();
      if (eff_dim(raw_h) * eff_dim(raw_w) > 256) raw_h = CFG_W'($urandom_range(1, 4));
      if ($urandom_range(0, 1) != 0) begin
        write_reg(CFG_FRAME_HEIGHT, raw_h);
        write_reg(CFG_FRAME_WIDTH, raw_w);
      end else begin
        write_reg(CFG_FRAME_WIDTH, raw_w);
        write_reg(CFG_FRAME_HEIGHT, raw_h);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_W'($urandom_range(0, 127)));
      h = eff_dim(raw_h);
      w = eff_dim(raw_w);
      n_frames = (h * w > 64) ? 2 : $urandom_range(2, 5);
      for (int f = 0; f < n_frames; f++) begin
        len = h * w;
        if (f == n_frames - 1 && $urandom_range(0, 3) == 0) len = $urandom_range(1, len);
        for (int k = 0; k < len; k++) send_pixel(PIX_W'($urandom_range(0, 255)));
        done_items += len;
      end
    end
  endtask

  // Long receiver hold-off while the sender keeps offering pixels.
  task automatic test_output_backpressure();
    write_reg(CFG_FRAME_HEIGHT, 7'd4);
    write_reg(CFG_FRAME_WIDTH, 7'd4);
    hold_request = 300;
    for (int i = 0; i < 48; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  // Test sequence.
  initial begin
    err_count     = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    hold_request  = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    reset_rotator_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_frame();
    test_degenerate_dims();
    test_small_rotation();

    tx_idle_pct = 22;
    rx_idle_pct = 48;
    test_extreme_dims();
    test_random_frames(480);

    tx_idle_pct = 48;
    rx_idle_pct = 22;
    test_random_frames(480);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_backpressure();
    test_random_frames(480);

    // Let every predicted pixel come out, then wait out the DRAIN_CYCLES margin.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rotated_pixels_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("image_rotate_90_tb: done, clean");
    end else begin
      $display("image_rotate_90_tb: done, errors");
    end
    $finish;
  end

endmodule
